// File: hdl/toeq_pkg.sv
// Package for the timestamp ordered event queue.
// Holds the shared widths, codes, state encoding and the cell command struct.
// No dependencies.
package toeq_pkg;

   localparam int TIME_WIDTH        = 64;
   localparam int DEPTH_DEFAULT     = 16;
   localparam int TAG_WIDTH_DEFAULT = 8;

   typedef logic [TIME_WIDTH-1:0] stamp_type;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_TICK   = 1'b1
   } mode_type;

   typedef enum logic {
      KIND_RELEASE = 1'b0,
      KIND_REJECT  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_RELEASE
   } state_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_cmd_type;

endpackage

// File: hdl/timestamp_ordered_event_queue.sv
// A tick goes straight to the release state. An insert first puts the event in order or, when
// the queue is full, strobes a reject; then all due events are released from the head in time
// order, each as its own result. All results are registered outputs.
// An insert shifts the cells from the insertion point on by one slot; a pop shifts the whole cell chain by one slot.
// Reset empties the queue at once; slot contents are not cleared.
// Results are strobed for one cycle each and the receiver cannot stall them.
module timestamp_ordered_event_queue import toeq_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int TAG_WIDTH = TAG_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_mode,
   input  logic [TAG_WIDTH-1:0] req_event_tag,
   input  stamp_type            req_event_time,
   input  stamp_type            req_now_time,
   output logic                 rsp_strobe,
   output logic                 rsp_kind,
   output logic [TAG_WIDTH-1:0] rsp_out_tag,
   output stamp_type            rsp_out_time,
   output logic                 rsp_last
);

   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [TAG_WIDTH-1:0]   tag_ff, tag_in;
   stamp_type              etime_ff, etime_in;
   stamp_type              now_ff, now_in;

   logic                   strobe_ff, strobe_in;
   logic                   kind_ff, kind_in;
   logic [TAG_WIDTH-1:0]   out_tag_ff, out_tag_in;
   stamp_type              out_time_ff, out_time_in;
   logic                   last_ff, last_in;

   cell_cmd_type           cmd;
   logic                   full;

   logic [DEPTH-1:0]       take;
   logic [DEPTH-1:0]       due;
   stamp_type              slot_time [DEPTH];
   logic [TAG_WIDTH-1:0]   slot_tag  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 occupied;
      logic                 left_take;
      stamp_type            left_time;
      logic [TAG_WIDTH-1:0] left_tag;
      stamp_type            right_time;
      logic [TAG_WIDTH-1:0] right_tag;

      assign occupied = count_ff > COUNT_WIDTH'(i);

      if (i == 0) begin : g_head
         assign left_take = 1'b0;
         assign left_time = slot_time[i];
         assign left_tag  = slot_tag[i];
      end else begin : g_body
         assign left_take = take[i-1];
         assign left_time = slot_time[i-1];
         assign left_tag  = slot_tag[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_time = slot_time[i];
         assign right_tag  = slot_tag[i];
      end else begin : g_inner
         assign right_time = slot_time[i+1];
         assign right_tag  = slot_tag[i+1];
      end

      toeq_cell #(
         .TAG_WIDTH(TAG_WIDTH)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (occupied),
         .new_time  (etime_ff),
         .new_tag   (tag_ff),
         .now_time  (now_ff),
         .left_take (left_take),
         .left_time (left_time),
         .left_tag  (left_tag),
         .right_time(right_time),
         .right_tag (right_tag),
         .take      (take[i]),
         .due       (due[i]),
         .slot_time (slot_time[i]),
         .slot_tag  (slot_tag[i])
      );
   end

   assign full = count_ff == COUNT_WIDTH'(DEPTH);
   assign busy = state_ff != ST_IDLE;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      tag_in      = tag_ff;
      etime_in    = etime_ff;
      now_in      = now_ff;
      strobe_in   = 1'b0;
      kind_in     = kind_ff;
      out_tag_in  = out_tag_ff;
      out_time_in = out_time_ff;
      last_in     = last_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               tag_in   = req_event_tag;
               etime_in = req_event_time;
               now_in   = req_now_time;
               state_in = (req_mode == MODE_TICK) ? ST_RELEASE : ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (full) begin
               strobe_in   = 1'b1;
               kind_in     = KIND_REJECT;
               out_tag_in  = tag_ff;
               out_time_in = etime_ff;
               last_in     = !due[0];
               state_in    = due[0] ? ST_RELEASE : ST_IDLE;
            end else begin
               cmd.insert = 1'b1;
               count_in   = count_ff + 1'b1;
               state_in   = ST_RELEASE;
            end
         end
         ST_RELEASE: begin
            if (due[0]) begin
               strobe_in   = 1'b1;
               kind_in     = KIND_RELEASE;
               out_tag_in  = slot_tag[0];
               out_time_in = slot_time[0];
               last_in     = !due[1];
               cmd.pop     = 1'b1;
               count_in    = count_ff - 1'b1;
               state_in    = due[1] ? ST_RELEASE : ST_IDLE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff      <= tag_in;
      etime_ff    <= etime_in;
      now_ff      <= now_in;
      kind_ff     <= kind_in;
      out_tag_ff  <= out_tag_in;
      out_time_ff <= out_time_in;
      last_ff     <= last_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_out_tag  = out_tag_ff;
   assign rsp_out_time = out_time_ff;
   assign rsp_last     = last_ff;

   // The fill count never passes the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("event count exceeds queue depth");

   // An accepted word always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start processing");

   // A word that is not the last one is followed by more release work.
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && !last_ff) |-> (state_ff == ST_RELEASE))
      else $error("non-final word without further release");

   // The last word of a run returns the block to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && last_ff) |-> (state_ff == ST_IDLE))
      else $error("final word while still busy");

endmodule

// File: hdl/toeq_cell.sv
// One slot of the sorted event chain: holds a time and a tag.
// Depends on toeq_pkg for the time type, the cell command struct and the default tag width.
module toeq_cell import toeq_pkg::*; #(
   parameter int TAG_WIDTH = TAG_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  cell_cmd_type         cmd,
   input  logic                 occupied,
   input  stamp_type            new_time,
   input  logic [TAG_WIDTH-1:0] new_tag,
   input  stamp_type            now_time,
   input  logic                 left_take,
   input  stamp_type            left_time,
   input  logic [TAG_WIDTH-1:0] left_tag,
   input  stamp_type            right_time,
   input  logic [TAG_WIDTH-1:0] right_tag,
   output logic                 take,
   output logic                 due,
   output stamp_type            slot_time,
   output logic [TAG_WIDTH-1:0] slot_tag
);

   stamp_type            time_ff, time_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;

   // A slot takes part in an insert when it is empty or holds a later time.
   assign take = !(occupied && (time_ff <= new_time));
   assign due  = occupied && (time_ff <= now_time);

   always_comb begin
      time_in = time_ff;
      tag_in  = tag_ff;
      if (cmd.insert && take) begin
         if (left_take) begin
            time_in = left_time;
            tag_in  = left_tag;
         end else begin
            time_in = new_time;
            tag_in  = new_tag;
         end
      end else if (cmd.pop) begin
         time_in = right_time;
         tag_in  = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      tag_ff  <= tag_in;
   end

   assign slot_time = time_ff;
   assign slot_tag  = tag_ff;

endmodule
